FILE: rtl/core/blfi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blfi_pkg
// Shared types and constants of the bucketed fingerprint index.
// ----------------------------------------------------------------------------
package blfi_pkg;

  localparam int unsigned CHUNK_W     = 17;
  localparam int unsigned CHUNK_RESET = 32768;
  localparam int unsigned BUCKET_IN_W = 10;
  localparam int unsigned KEY_HIGH_W  = 64;
  localparam int unsigned KEY_MID_W   = 64;
  localparam int unsigned KEY_LOW_W   = 32;
  localparam int unsigned KEY_FULL_W  = 160;
  localparam int unsigned SLOT_OUT_W  = 5;
  localparam int unsigned LOC_W       = 31;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_EVAL  = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_LOAD  = 6'b100000
  } blfi_state_e;

  typedef struct packed {
    logic clr;
    logic capture;
    logic rd;
    logic eval;
    logic wr;
    logic load;
  } blfi_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } blfi_status_t;

endpackage

FILE: rtl/core/blfi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blfi_ctrl
// Sequencer: clearing pass, then read / compare / write back / output load.
// ----------------------------------------------------------------------------
module blfi_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  blfi_pkg::blfi_status_t status_i,
  output blfi_pkg::blfi_cmd_t    cmd_o
);

  blfi_pkg::blfi_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= blfi_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      blfi_pkg::ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) state_d = blfi_pkg::ST_IDLE;
      end
      blfi_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = blfi_pkg::ST_READ;
        end
      end
      blfi_pkg::ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = blfi_pkg::ST_EVAL;
      end
      blfi_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = blfi_pkg::ST_WRITE;
      end
      blfi_pkg::ST_WRITE: begin
        cmd_o.wr = 1'b1;
        state_d  = blfi_pkg::ST_LOAD;
      end
      blfi_pkg::ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = blfi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = blfi_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

FILE: rtl/core/blfi_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blfi_dp
// Datapath: bucket row memories, fill counts, compare, LRU update, location.
// ----------------------------------------------------------------------------
module blfi_dp #(
  parameter int unsigned BUCKETS  = 1024,
  parameter int unsigned SLOTS    = 32,
  parameter int unsigned KEY_BITS = 160
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  blfi_pkg::blfi_cmd_t                  cmd_i,
  output blfi_pkg::blfi_status_t               status_o,
  input  logic                                 kind_i,
  input  logic [blfi_pkg::BUCKET_IN_W-1:0]     bucket_i,
  input  logic [blfi_pkg::KEY_HIGH_W-1:0]      key_high_i,
  input  logic [blfi_pkg::KEY_MID_W-1:0]       key_mid_i,
  input  logic [blfi_pkg::KEY_LOW_W-1:0]       key_low_i,
  input  logic                                 cfg_valid_i,
  input  logic [blfi_pkg::CHUNK_W-1:0]         cfg_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 hit_o,
  output logic [blfi_pkg::SLOT_OUT_W-1:0]      slot_o,
  output logic [blfi_pkg::LOC_W-1:0]           cache_location_o
);

  localparam int unsigned BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned FW   = $clog2(SLOTS + 1);
  localparam int unsigned IW   = BW + SW;
  localparam int unsigned PW   = IW + blfi_pkg::CHUNK_W;
  localparam int unsigned KROW = SLOTS * KEY_BITS;
  localparam int unsigned RROW = SLOTS * SW;

  // configuration
  logic [blfi_pkg::CHUNK_W-1:0] chunk_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= blfi_pkg::CHUNK_W'(blfi_pkg::CHUNK_RESET);
    end else if (cfg_valid_i) begin
      chunk_q <= cfg_data_i;
    end
  end

  // bucket modulo BUCKETS by restoring subtraction
  logic [BW-1:0] bucket_mod;
  always_comb begin
    logic [blfi_pkg::BUCKET_IN_W-1:0] r;
    r = bucket_i;
    for (int k = blfi_pkg::BUCKET_IN_W - 1; k >= 0; k--) begin
      if (32'(r) >= (BUCKETS << k)) r = r - blfi_pkg::BUCKET_IN_W'(BUCKETS << k);
    end
    bucket_mod = BW'(r);
  end

  logic [blfi_pkg::KEY_FULL_W-1:0] key_full;
  assign key_full = {key_high_i, key_mid_i, key_low_i};

  logic                kind_q;
  logic [BW-1:0]       bucket_q;
  logic [KEY_BITS-1:0] key_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q   <= kind_i;
      bucket_q <= bucket_mod;
      key_q    <= key_full[KEY_BITS-1:0];
    end
  end

  // clearing pass over the fill counts
  logic [BW-1:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_q <= clr_q + 1'b1;
    end
  end
  assign status_o.clr_last = (clr_q == BW'(BUCKETS - 1));

  // memories
  logic [KROW-1:0] key_mem  [BUCKETS];
  logic [RROW-1:0] rank_mem [BUCKETS];
  logic [FW-1:0]   fill_mem [BUCKETS];
  logic [KROW-1:0] krow_rd;
  logic [RROW-1:0] rrow_rd;
  logic [FW-1:0]   fill_rd;

  logic            hit_q;
  logic [SW-1:0]   slot_q;
  logic [FW-1:0]   old_q;
  logic            free_q;
  logic [KROW-1:0] krow_wr;
  logic [RROW-1:0] rrow_wr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      krow_rd <= key_mem[bucket_q];
      rrow_rd <= rank_mem[bucket_q];
      fill_rd <= fill_mem[bucket_q];
    end
    if (cmd_i.wr && kind_q && !hit_q) key_mem[bucket_q] <= krow_wr;
    if (cmd_i.wr && kind_q) rank_mem[bucket_q] <= rrow_wr;
    if (cmd_i.clr) begin
      fill_mem[clr_q] <= '0;
    end else if (cmd_i.wr && kind_q && !hit_q && free_q) begin
      fill_mem[bucket_q] <= fill_rd + 1'b1;
    end
  end

  // compare and victim choice
  logic          hit_c;
  logic [SW-1:0] hslot_c;
  logic [SW-1:0] victim_c;
  logic          free_c;
  logic [SW-1:0] slot_c;
  logic [FW-1:0] old_c;
  always_comb begin
    hit_c    = 1'b0;
    hslot_c  = '0;
    victim_c = '0;
    for (int j = SLOTS - 1; j >= 0; j--) begin
      if ((FW'(j) < fill_rd) && (krow_rd[j*KEY_BITS +: KEY_BITS] == key_q)) begin
        hit_c   = 1'b1;
        hslot_c = SW'(j);
      end
      // ranks of a full bucket are a permutation, oldest has rank SLOTS-1
      if (rrow_rd[j*SW +: SW] == SW'(SLOTS - 1)) victim_c = SW'(j);
    end
    free_c = (fill_rd < FW'(SLOTS));
    if (hit_c) begin
      slot_c = hslot_c;
      old_c  = FW'(rrow_rd[hslot_c*SW +: SW]);
    end else if (free_c) begin
      slot_c = SW'(fill_rd);
      old_c  = FW'(SLOTS);
    end else begin
      slot_c = victim_c;
      old_c  = FW'(rrow_rd[victim_c*SW +: SW]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      hit_q  <= hit_c;
      slot_q <= slot_c;
      old_q  <= old_c;
      free_q <= free_c;
    end
  end

  // write-back rows
  always_comb begin
    krow_wr = krow_rd;
    krow_wr[slot_q*KEY_BITS +: KEY_BITS] = key_q;
    rrow_wr = rrow_rd;
    for (int j = 0; j < SLOTS; j++) begin
      if (SW'(j) == slot_q) begin
        rrow_wr[j*SW +: SW] = '0;
      end else if ((FW'(j) < fill_rd) && (FW'(rrow_rd[j*SW +: SW]) < old_q)) begin
        rrow_wr[j*SW +: SW] = rrow_rd[j*SW +: SW] + 1'b1;
      end
    end
  end

  // byte location
  logic [IW-1:0]             idx;
  logic [blfi_pkg::LOC_W-1:0] loc_q;
  logic [PW-1:0]             prod;
  assign idx  = IW'(bucket_q) * IW'(SLOTS) + IW'(slot_q);
  assign prod = PW'(idx) * PW'(chunk_q);
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) loc_q <= blfi_pkg::LOC_W'(prod);
  end

  // output word
  logic              out_valid_q;
  logic [SW+4:0]     slot_ext;
  logic              report;
  assign slot_ext = (SW + 5)'(slot_q);
  assign report   = (kind_q == blfi_pkg::KIND_UPDATE) || hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hit_o            <= hit_q;
      slot_o           <= report ? slot_ext[blfi_pkg::SLOT_OUT_W-1:0] : '0;
      cache_location_o <= report ? loc_q : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.eval |-> (fill_rd <= FW'(SLOTS)))
    else $error("fill count above slot count");

  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr && hit_q) |-> (FW'(slot_q) < fill_rd))
    else $error("hit on an invalid slot");

endmodule

FILE: rtl/core/bucketed_lru_fingerprint_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucketed_lru_fingerprint_index
// Set-associative fingerprint lookup with per-bucket LRU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i/in_ready_o) carries kind, bucket and the
//   fingerprint. Result channel (out_valid_o/out_ready_i) returns one word
//   per request: hit, slot and byte location. cfg_valid_i writes chunk_size;
//   cfg_ready_o is always high.
//   One request is in flight at a time: accept, row read, compare, write
//   back, output load, in that order.
//   The result word is registered at the end of the output load step.
//   The step sequence is set by the single-port bucket row read and write back.
//   The next request is accepted while the previous result still waits in
//   the output register; a stalled receiver holds the block in its load step.
//   After reset a clearing pass zeroes the fill counts, one bucket per cycle;
//   no request is accepted until it ends.
// ----------------------------------------------------------------------------
module bucketed_lru_fingerprint_index #(
  parameter int unsigned BUCKETS  = 1024,
  parameter int unsigned SLOTS    = 32,
  parameter int unsigned KEY_BITS = 160
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             kind_i,
  input  logic [blfi_pkg::BUCKET_IN_W-1:0] bucket_i,
  input  logic [blfi_pkg::KEY_HIGH_W-1:0]  key_high_i,
  input  logic [blfi_pkg::KEY_MID_W-1:0]   key_mid_i,
  input  logic [blfi_pkg::KEY_LOW_W-1:0]   key_low_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             hit_o,
  output logic [blfi_pkg::SLOT_OUT_W-1:0]  slot_o,
  output logic [blfi_pkg::LOC_W-1:0]       cache_location_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [blfi_pkg::CHUNK_W-1:0]     cfg_data_i
);

  blfi_pkg::blfi_cmd_t    cmd;
  blfi_pkg::blfi_status_t status;

  assign cfg_ready_o = 1'b1;

  blfi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  blfi_dp #(
    .BUCKETS  (BUCKETS),
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .kind_i           (kind_i),
    .bucket_i         (bucket_i),
    .key_high_i       (key_high_i),
    .key_mid_i        (key_mid_i),
    .key_low_i        (key_low_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .hit_o            (hit_o),
    .slot_o           (slot_o),
    .cache_location_o (cache_location_o)
  );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bucketed_lru_fingerprint_index. A predictor inside
// the bench keeps its own copy of every bucket (keys, valid bits, recency
// ranks) and the chunk size. It works out hit, slot and byte location for
// each accepted request. Results are checked in order against it, under
// random sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NUM_BUCKETS = 1024;
  localparam int NUM_SLOTS   = 32;
  localparam int ENTRIES     = NUM_BUCKETS * NUM_SLOTS;
  localparam int IDLE_LIMIT  = 6000;
  localparam int SETTLE      = 12;

  typedef struct packed {
    logic                            hit;
    logic [blfi_pkg::SLOT_OUT_W-1:0] slot;
    logic [blfi_pkg::LOC_W-1:0]      location;
  } index_result_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_ready_o;
  logic                             kind_i;
  logic [blfi_pkg::BUCKET_IN_W-1:0] bucket_i;
  logic [blfi_pkg::KEY_HIGH_W-1:0]  key_high_i;
  logic [blfi_pkg::KEY_MID_W-1:0]   key_mid_i;
  logic [blfi_pkg::KEY_LOW_W-1:0]   key_low_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  logic                             hit_o;
  logic [blfi_pkg::SLOT_OUT_W-1:0]  slot_o;
  logic [blfi_pkg::LOC_W-1:0]       cache_location_o;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [blfi_pkg::CHUNK_W-1:0]     cfg_data_i;

  bucketed_lru_fingerprint_index DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .bucket_i         (bucket_i),
    .key_high_i       (key_high_i),
    .key_mid_i        (key_mid_i),
    .key_low_i        (key_low_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .hit_o            (hit_o),
    .slot_o           (slot_o),
    .cache_location_o (cache_location_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  // shadow copy of the index
  bit [blfi_pkg::KEY_FULL_W-1:0] shadow_key [ENTRIES];
  bit                            shadow_valid [ENTRIES];
  int                            shadow_rank [ENTRIES];
  bit [blfi_pkg::CHUNK_W-1:0]    shadow_chunk;

  index_result_t pending_results[$];
  int            errors;
  int            items_sent;
  int            hits_seen;
  int            evictions;
  int            results_checked;
  int            idle_cycles;
  bit            hold_off;
  bit            no_gaps;

  bit [blfi_pkg::KEY_FULL_W-1:0] key_pool [48];
  int                            hot_buckets [4] = '{0, 1023, 5, 517};

  initial clk_i = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic index_result_t lookup_or_update(bit kind,
                                                     bit [blfi_pkg::BUCKET_IN_W-1:0] bucket,
                                                     bit [blfi_pkg::KEY_FULL_W-1:0] key);
    index_result_t res;
    int base;
    int s;
    int old;
    int best;
    bit found;
    bit have_free;
    longint unsigned loc;
    base  = int'(bucket) * NUM_SLOTS;
    s     = 0;
    found = 1'b0;
    res   = '0;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      if (shadow_valid[base + j] && shadow_key[base + j] == key) begin
        s = j;
        found = 1'b1;
        break;
      end
    end
    if (kind == blfi_pkg::KIND_LOOKUP && !found) return res;
    if (kind == blfi_pkg::KIND_UPDATE) begin
      if (found) begin
        old = shadow_rank[base + s];
      end else begin
        old = NUM_SLOTS;
        have_free = 1'b0;
        for (int j = 0; j < NUM_SLOTS; j++) begin
          if (!shadow_valid[base + j]) begin
            s = j;
            have_free = 1'b1;
            break;
          end
        end
        if (!have_free) begin
          // least recent wins, lowest slot on a tie
          best = 0;
          s = 0;
          for (int j = 0; j < NUM_SLOTS; j++) begin
            if (shadow_rank[base + j] > best) begin
              best = shadow_rank[base + j];
              s = j;
            end
          end
          old = shadow_rank[base + s];
          evictions++;
        end
        shadow_key[base + s] = key;
      end
      for (int j = 0; j < NUM_SLOTS; j++) begin
        if (j != s && shadow_valid[base + j] && shadow_rank[base + j] < old)
          shadow_rank[base + j]++;
      end
      shadow_rank[base + s]  = 0;
      shadow_valid[base + s] = 1'b1;
    end
    loc = longint'(base + s) * longint'(shadow_chunk);
    res.hit      = found;
    res.slot     = s[blfi_pkg::SLOT_OUT_W-1:0];
    res.location = loc[blfi_pkg::LOC_W-1:0];
    return res;
  endfunction

  // called right after a falling edge; returns right after a falling edge, once the request has been accepted
  task automatic send_request(bit kind, bit [blfi_pkg::BUCKET_IN_W-1:0] bucket,
                              bit [blfi_pkg::KEY_FULL_W-1:0] key);
    index_result_t res;
    kind_i     <= kind;
    bucket_i   <= bucket;
    key_high_i <= key[159:96];
    key_mid_i  <= key[95:32];
    key_low_i  <= key[31:0];
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    res = lookup_or_update(kind, bucket, key);
    if (res.hit) hits_seen++;
    pending_results.push_back(res);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic pause_sender(int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_chunk_size(bit [blfi_pkg::CHUNK_W-1:0] value);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_chunk = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic bit [blfi_pkg::KEY_FULL_W-1:0] random_key();
    return {$urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic send_random(int count);
    int burst;
    int pick;
    bit [blfi_pkg::KEY_FULL_W-1:0] key;
    bit [blfi_pkg::BUCKET_IN_W-1:0] bucket;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if (!no_gaps) pause_sender($urandom_range(0, 6));
      end
      burst--;
      pick = $urandom_range(0, 99);
      if (pick < 70) key = key_pool[$urandom_range(0, 47)];
      else if (pick < 85) begin
        // near miss: one bit off a known key
        key = key_pool[$urandom_range(0, 47)];
        key[$urandom_range(0, blfi_pkg::KEY_FULL_W - 1)] ^= 1'b1;
      end else key = random_key();
      if ($urandom_range(0, 3) != 0) begin
        bucket = blfi_pkg::BUCKET_IN_W'(hot_buckets[$urandom_range(0, 3)]);
      end else begin
        bucket = blfi_pkg::BUCKET_IN_W'($urandom_range(0, NUM_BUCKETS - 1));
      end
      send_request(1'($urandom_range(0, 1)), bucket, key);
    end
  endtask

  task automatic test_empty_lookups();
    send_request(blfi_pkg::KIND_LOOKUP, 10'd0, '0);
    send_request(blfi_pkg::KIND_LOOKUP, 10'd1023, '1);
    send_request(blfi_pkg::KIND_LOOKUP, 10'd5, random_key());
  endtask

  task automatic test_insert_and_promote();
    bit [blfi_pkg::KEY_FULL_W-1:0] key;
    key = random_key();
    send_request(blfi_pkg::KIND_UPDATE, 10'd0, '0);
    send_request(blfi_pkg::KIND_UPDATE, 10'd1023, '1);
    send_request(blfi_pkg::KIND_LOOKUP, 10'd0, '0);
    send_request(blfi_pkg::KIND_LOOKUP, 10'd1023, '1);
    send_request(blfi_pkg::KIND_LOOKUP, 10'd0, '1);
    send_request(blfi_pkg::KIND_UPDATE, 10'd1023, key);
    send_request(blfi_pkg::KIND_UPDATE, 10'd1023, '1);
    send_request(blfi_pkg::KIND_LOOKUP, 10'd1023, key);
    // keys that differ from a stored one only at the top or bottom bit
    send_request(blfi_pkg::KIND_LOOKUP, 10'd1023, key ^ (160'd1 << 159));
    send_request(blfi_pkg::KIND_LOOKUP, 10'd1023, key ^ 160'd1);
    send_request(blfi_pkg::KIND_UPDATE, 10'd1023, key ^ 160'd1);
    send_request(blfi_pkg::KIND_LOOKUP, 10'd1023, key ^ 160'd1);
    send_request(blfi_pkg::KIND_UPDATE, 10'd0, '0);
  endtask

  task automatic test_long_stall();
    no_gaps = 1'b1;
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      send_random(40);
    join
    no_gaps = 1'b0;
  endtask

  task automatic test_chunk_sizes();
    bit [blfi_pkg::CHUNK_W-1:0] sizes [6];
    sizes = '{17'd1, 17'd65536, 17'h1FFFF, 17'd0, 17'd32768, 17'd0};
    sizes[5] = blfi_pkg::CHUNK_W'($urandom_range(2, 65535));
    foreach (sizes[i]) begin
      wait_idle();
      write_chunk_size(sizes[i]);
      no_gaps = (i == 2);
      send_random(290);
    end
    no_gaps = 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      index_result_t exp_res;
      if (pending_results.size() == 0) begin
        $display("%0t: result word with nothing expected (hit %0b slot %0d loc %0d)",
                 $time, hit_o, slot_o, cache_location_o);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        results_checked++;
        if (hit_o !== exp_res.hit) begin
          $display("%0t: hit mismatch expected %0b actual %0b", $time, exp_res.hit, hit_o);
          errors++;
        end
        if (slot_o !== exp_res.slot) begin
          $display("%0t: slot mismatch expected %0d actual %0d", $time, exp_res.slot, slot_o);
          errors++;
        end
        if (cache_location_o !== exp_res.location) begin
          $display("%0t: location mismatch expected %0d actual %0d",
                   $time, exp_res.location, cache_location_o);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern, changes mode at random
  initial begin
    int mode;
    out_ready_i = 1'b0;
    mode = 0;
    forever begin
      @(negedge clk_i);
      if (($urandom_range(0, 63)) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_ready_i <= !hold_off;
        1: out_ready_i <= !hold_off && $urandom_range(0, 1);
        2: out_ready_i <= !hold_off && ($urandom_range(0, 3) == 0);
        default: out_ready_i <= !hold_off && ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    errors = 0;
    items_sent = 0;
    hits_seen = 0;
    evictions = 0;
    results_checked = 0;
    hold_off = 1'b0;
    no_gaps = 1'b0;
    shadow_chunk = blfi_pkg::CHUNK_W'(blfi_pkg::CHUNK_RESET);
    in_valid_i = 1'b0;
    kind_i = blfi_pkg::KIND_LOOKUP;
    bucket_i = '0;
    key_high_i = '0;
    key_mid_i = '0;
    key_low_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    foreach (key_pool[i]) key_pool[i] = random_key();
    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_lookups();
    test_insert_and_promote();
    test_long_stall();
    test_chunk_sizes();
    wait_idle();

    $display("%0d requests, %0d results checked, %0d hits, %0d evictions, 6 chunk sizes",
             items_sent, results_checked, hits_seen, evictions);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/blfi_pkg.sv
rtl/core/blfi_ctrl.sv
rtl/core/blfi_dp.sv
rtl/core/bucketed_lru_fingerprint_index.sv
dv/testbench.sv
